### hdl/tdc_ehd_pkg.sv
`timescale 1ns / 1ps
// tdc_ehd_pkg: types and constants shared by the readout word decoder
// word type codes, field widths, command and configuration structs
// no dependencies
package tdc_ehd_pkg;

  localparam logic [4:0] WT_HIT     = 5'h00;
  localparam logic [4:0] WT_ERROR   = 5'h04;
  localparam logic [4:0] WT_HEADER  = 5'h08;
  localparam logic [4:0] WT_TRAILER = 5'h10;

  localparam logic [1:0] CFG_REF_CHANNEL   = 2'd0;
  localparam logic [1:0] CFG_CHANNELS_USED = 2'd1;
  localparam logic [1:0] CFG_HITS_KEPT     = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam int CHANNEL_W = 7;
  localparam int ORDER_W   = 4;
  localparam int TIME_W    = 19;
  localparam int COUNT_W   = 5;
  localparam int ENTRY_W   = CHANNEL_W + ORDER_W + TIME_W;
  localparam int ORDER_CAP = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  typedef enum logic [1:0] {
    OP_HEADER,
    OP_HIT,
    OP_ERROR,
    OP_TRAILER
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [26:0] body;
  } cmd_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0] ref_channel;
    logic [7:0]           channels_in_use;
    logic [COUNT_W-1:0]   hits_kept;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HIT_UPD,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } back_state_t;

endpackage

### hdl/tdc_ehd_if.sv
`timescale 1ns / 1ps
// tdc_ehd_word_if and tdc_ehd_hit_if: valid/ready channels of the decoder
// readout words in, decoded hit results out; no dependencies
interface tdc_ehd_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;

  modport source (output valid, output data_word, input ready);
  modport sink (input valid, input data_word, output ready);
endinterface

interface tdc_ehd_hit_if;
  logic               valid;
  logic               ready;
  logic               has_hit;
  logic [6:0]         hit_channel;
  logic [3:0]         hit_order;
  logic signed [19:0] relative_time;
  logic [21:0]        event_number;
  logic [4:0]         module_address;
  logic               address_mismatch;
  logic [2:0]         trailer_status;
  logic [14:0]        last_error_flags;
  logic               hits_dropped;
  logic               last_of_event;

  modport source (
    output valid, output has_hit, output hit_channel, output hit_order,
    output relative_time, output event_number, output module_address,
    output address_mismatch, output trailer_status, output last_error_flags,
    output hits_dropped, output last_of_event, input ready
  );
  modport sink (
    input valid, input has_hit, input hit_channel, input hit_order,
    input relative_time, input event_number, input module_address,
    input address_mismatch, input trailer_status, input last_error_flags,
    input hits_dropped, input last_of_event, output ready
  );
endinterface

### hdl/tdc_event_hit_decoder.sv
`timescale 1ns / 1ps
// tdc_event_hit_decoder: multihit tdc readout word decoder, top level
// configuration registers, front classifier, command queue and back end
// uses tdc_ehd_pkg, tdc_ehd_if, tdc_ehd_front, tdc_ehd_fifo, tdc_ehd_back
//
//   channel  direction  beat
//   word     in         one 32-bit readout word
//   hit      out        one decoded hit result
//   cfg      in         register write, index and data
//
// header and error words are handled in the back end at dispatch; hit words take
// a channel counter memory read, then an update; a trailer takes, per result,
// a hit store read, then an output register load, the first read overlapping
// dispatch, and waits while the result beat is held off
// the front takes a word every cycle while the 2-entry queue has room
// reset clears all counters through valid bits at once, no clearing pass
module tdc_event_hit_decoder #(
  parameter int NUM_CHANNELS   = 128,
  parameter int MAX_DEPTH      = 16,
  parameter int HIT_STORE_SIZE = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  tdc_ehd_word_if.sink                        word,
  tdc_ehd_hit_if.source                       hit,
  input  logic                                cfg_write,
  input  logic [tdc_ehd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tdc_ehd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tdc_ehd_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic empty;
  logic full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_channel     <= '0;
      cfg.channels_in_use <= 8'd128;
      cfg.hits_kept       <= 5'd4;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_REF_CHANNEL:   cfg.ref_channel     <= cfg_data[CHANNEL_W-1:0];
        CFG_CHANNELS_USED: cfg.channels_in_use <= cfg_data;
        CFG_HITS_KEPT:     cfg.hits_kept       <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  tdc_ehd_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .word (word),
    .cfg  (cfg),
    .full (full),
    .push (push),
    .cmd  (push_cmd)
  );

  tdc_ehd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  tdc_ehd_back #(
    .NUM_CHANNELS   (NUM_CHANNELS),
    .MAX_DEPTH      (MAX_DEPTH),
    .HIT_STORE_SIZE (HIT_STORE_SIZE)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .hit   (hit)
  );

endmodule

### hdl/tdc_ehd_ram.sv
`timescale 1ns / 1ps
// tdc_ehd_ram: generic single write port, single read port ram
// registered read; no dependencies
module tdc_ehd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/tdc_ehd_front.sv
`timescale 1ns / 1ps
// tdc_ehd_front: accepts readout words, classifies them by type
// drops ignored words and out-of-range hits; uses tdc_ehd_pkg, tdc_ehd_if
module tdc_ehd_front #(
  parameter int NUM_CHANNELS = 128
) (
  tdc_ehd_word_if.sink         word,
  input  tdc_ehd_pkg::cfg_t    cfg,
  input  logic                 full,
  output logic                 push,
  output tdc_ehd_pkg::cmd_t    cmd
);
  import tdc_ehd_pkg::*;

  logic [4:0]           kind;
  logic [CHANNEL_W-1:0] ch;
  logic                 keep;

  assign kind = word.data_word[31:27];
  assign ch   = word.data_word[25:19];

  always_comb begin
    keep     = 1'b0;
    cmd.op   = OP_HIT;
    cmd.body = word.data_word[26:0];
    case (kind)
      WT_HEADER: begin
        keep   = 1'b1;
        cmd.op = OP_HEADER;
      end
      WT_ERROR: begin
        keep   = 1'b1;
        cmd.op = OP_ERROR;
      end
      WT_TRAILER: begin
        keep   = 1'b1;
        cmd.op = OP_TRAILER;
      end
      WT_HIT: begin
        keep   = ({1'b0, ch} < cfg.channels_in_use) && ({1'b0, ch} < 8'(NUM_CHANNELS));
        cmd.op = OP_HIT;
      end
      default: keep = 1'b0;
    endcase
  end

  assign word.ready = !full;
  assign push       = word.valid && !full && keep;

endmodule

### hdl/tdc_ehd_fifo.sv
`timescale 1ns / 1ps
// tdc_ehd_fifo: short command queue between front and back
// uses tdc_ehd_pkg
module tdc_ehd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tdc_ehd_pkg::cmd_t push_cmd,
  input  logic              pop,
  output tdc_ehd_pkg::cmd_t head,
  output logic              empty,
  output logic              full
);
  import tdc_ehd_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

### hdl/tdc_ehd_back.sv
`timescale 1ns / 1ps
// tdc_ehd_back: executes queued commands, keeps event state and the hit store
// walks the store on a trailer; uses tdc_ehd_pkg, tdc_ehd_if, tdc_ehd_ram
module tdc_ehd_back #(
  parameter int NUM_CHANNELS   = 128,
  parameter int MAX_DEPTH      = 16,
  parameter int HIT_STORE_SIZE = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  tdc_ehd_pkg::cfg_t cfg,
  input  tdc_ehd_pkg::cmd_t head,
  input  logic              empty,
  output logic              pop,
  tdc_ehd_hit_if.source     hit
);
  import tdc_ehd_pkg::*;

  localparam int CH_AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SA        = (HIT_STORE_SIZE > 1) ? $clog2(HIT_STORE_SIZE) : 1;
  localparam int SW        = $clog2(HIT_STORE_SIZE + 1);
  localparam int DEPTH_CAP = (MAX_DEPTH < ORDER_CAP) ? MAX_DEPTH : ORDER_CAP;

  back_state_t          state;
  back_state_t          state_next;
  logic [CHANNEL_W-1:0] cmd_ch;
  logic [TIME_W-1:0]    cmd_time;
  logic [NUM_CHANNELS-1:0] count_valid;
  logic [SW-1:0]        stored;
  logic [SW-1:0]        walk_idx;
  logic [TIME_W-1:0]    ref_time;
  logic [4:0]           hdr_addr;
  logic [21:0]          hdr_count;
  logic [14:0]          err_flags;
  logic                 overflow;
  logic                 mism;
  logic [2:0]           status;
  logic                 empty_evt;

  logic [CHANNEL_W-1:0] head_ch;
  logic [COUNT_W-1:0]   cnt_rdata;
  logic [COUNT_W-1:0]   ord;
  logic [COUNT_W-1:0]   depth;
  logic                 keep_hit;
  logic                 store_room;
  logic                 cnt_we;
  logic [COUNT_W-1:0]   cnt_wdata;
  logic                 st_we;
  logic [ENTRY_W-1:0]   st_wdata;
  logic [SA-1:0]        st_raddr;
  logic [ENTRY_W-1:0]   st_rdata;
  logic                 walk_last;
  logic                 slot_free;
  logic                 load;
  logic [TIME_W:0]      rel_time;

  assign head_ch    = head.body[25:19];
  assign ord        = count_valid[cmd_ch[CH_AW-1:0]] ? cnt_rdata : '0;
  assign depth      = (cfg.hits_kept > COUNT_W'(DEPTH_CAP)) ? COUNT_W'(DEPTH_CAP)
                                                            : cfg.hits_kept;
  assign keep_hit   = (ord < depth);
  assign store_room = (stored < SW'(HIT_STORE_SIZE));
  assign cnt_we     = (state == ST_HIT_UPD);
  assign cnt_wdata  = (ord == COUNT_MAX) ? ord : ord + 1'b1;
  assign st_we      = (state == ST_HIT_UPD) && keep_hit && store_room;
  assign st_wdata   = {cmd_ch, ord[ORDER_W-1:0], cmd_time};
  assign st_raddr   = (state == ST_IDLE) ? '0 : walk_idx[SA-1:0];
  assign walk_last  = ((walk_idx + SW'(1)) == stored);
  assign slot_free  = !hit.valid || hit.ready;
  assign load       = (state == ST_EMIT_OUT) && slot_free;
  assign rel_time   = {1'b0, st_rdata[TIME_W-1:0]} - {1'b0, ref_time};

  tdc_ehd_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_CHANNELS)
  ) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cmd_ch[CH_AW-1:0]),
    .wdata (cnt_wdata),
    .raddr (head_ch[CH_AW-1:0]),
    .rdata (cnt_rdata)
  );

  tdc_ehd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HIT_STORE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (stored[SA-1:0]),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          case (head.op)
            OP_HIT:     state_next = ST_HIT_UPD;
            OP_TRAILER: state_next = ST_EMIT_OUT;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_HIT_UPD: state_next = ST_IDLE;
      ST_EMIT_RD: state_next = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (slot_free) begin
          state_next = (empty_evt || walk_last) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count_valid <= '0;
      stored      <= '0;
      ref_time    <= '0;
      hdr_addr    <= '0;
      hdr_count   <= '0;
      err_flags   <= '0;
      overflow    <= 1'b0;
      hit.valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        hit.valid <= 1'b1;
      end else if (hit.ready) begin
        hit.valid <= 1'b0;
      end
      if (state == ST_IDLE && !empty) begin
        case (head.op)
          OP_HEADER: begin
            hdr_addr    <= head.body[4:0];
            hdr_count   <= head.body[26:5];
            count_valid <= '0;
            stored      <= '0;
            overflow    <= 1'b0;
          end
          OP_ERROR: err_flags <= head.body[14:0];
          default: ;
        endcase
      end
      if (state == ST_HIT_UPD) begin
        if (cmd_ch == cfg.ref_channel && ord == '0) begin
          ref_time <= cmd_time;
        end
        count_valid[cmd_ch[CH_AW-1:0]] <= 1'b1;
        if (keep_hit) begin
          if (store_room) begin
            stored <= stored + 1'b1;
          end else begin
            overflow <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && !empty) begin
      case (head.op)
        OP_HIT: begin
          cmd_ch   <= head_ch;
          cmd_time <= head.body[TIME_W-1:0];
        end
        OP_TRAILER: begin
          mism      <= (head.body[4:0] != hdr_addr);
          status    <= head.body[26:24];
          walk_idx  <= '0;
          empty_evt <= (stored == '0);
        end
        default: ;
      endcase
    end
    if (load) begin
      walk_idx             <= walk_idx + 1'b1;
      hit.has_hit          <= !empty_evt;
      hit.hit_channel      <= empty_evt ? '0 : st_rdata[ENTRY_W-1 -: CHANNEL_W];
      hit.hit_order        <= empty_evt ? '0 : st_rdata[TIME_W +: ORDER_W];
      hit.relative_time    <= empty_evt ? '0 : signed'(rel_time);
      hit.event_number     <= hdr_count;
      hit.module_address   <= hdr_addr;
      hit.address_mismatch <= mism;
      hit.trailer_status   <= status;
      hit.last_error_flags <= err_flags;
      hit.hits_dropped     <= overflow;
      hit.last_of_event    <= empty_evt || walk_last;
    end
  end

endmodule

### tb/tdc_event_hit_decoder_test.sv
`timescale 1ns / 1ps
// tdc_event_hit_decoder_test: self-checking bench for the readout word decoder
// predicts decoded hits per trailer and checks every result beat against them
// uses tdc_ehd_pkg, tdc_ehd_if and tdc_event_hit_decoder
module tdc_event_hit_decoder_test;
  import tdc_ehd_pkg::*;

  localparam int NUM_CHANNELS   = 128;
  localparam int MAX_DEPTH      = 16;
  localparam int HIT_STORE_SIZE = 64;
  localparam int IDLE_PERCENT   = 23;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_CYCLES    = 500;
  localparam int QUIET_LIMIT    = 3000;
  localparam int PRINT_LIMIT    = 100;

  localparam logic [4:0] WT_TDC_HEADER  = 5'h01;
  localparam logic [4:0] WT_TDC_TRAILER = 5'h03;
  localparam logic [4:0] WT_FILLER      = 5'h1F;

  typedef struct {
    logic        has_hit;
    logic [6:0]  hit_channel;
    logic [3:0]  hit_order;
    logic [19:0] relative_time;
    logic [21:0] event_number;
    logic [4:0]  module_address;
    logic        address_mismatch;
    logic [2:0]  trailer_status;
    logic [14:0] last_error_flags;
    logic        hits_dropped;
    logic        last_of_event;
  } hit_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tdc_ehd_word_if word_ch();
  tdc_ehd_hit_if hit_ch();

  tdc_event_hit_decoder #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .MAX_DEPTH(MAX_DEPTH),
    .HIT_STORE_SIZE(HIT_STORE_SIZE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .word(word_ch),
    .hit(hit_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] words_to_send[$];
  hit_result_t hits_due[$];
  int mismatches = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_taken = 1'b0;
  logic hold_req = 1'b0;
  logic steady = 1'b0;

  // decoder shadow: configuration
  logic [6:0] reg_ref_channel = 7'd0;
  logic [7:0] reg_channels = 8'd128;
  logic [4:0] reg_hits_kept = 5'd4;

  // decoder shadow: event state
  logic [4:0]  chan_counts[NUM_CHANNELS];
  logic [6:0]  store_channel[HIT_STORE_SIZE];
  logic [3:0]  store_order[HIT_STORE_SIZE];
  logic [18:0] store_time[HIT_STORE_SIZE];
  int          stored_hits = 0;
  logic [18:0] ref_time = '0;
  logic [4:0]  hdr_address = '0;
  logic [21:0] hdr_events = '0;
  logic [14:0] error_flags = '0;
  logic        store_overflow = 1'b0;

  initial foreach (chan_counts[i]) chan_counts[i] = '0;

  task automatic decode_word(input logic [31:0] w);
    hit_result_t r;
    logic [6:0] ch;
    logic [18:0] t;
    logic [4:0] ord;
    int limit;
    int depth;
    case (w[31:27])
      WT_HEADER: begin
        hdr_address = w[4:0];
        hdr_events = w[26:5];
        foreach (chan_counts[i]) chan_counts[i] = '0;
        stored_hits = 0;
        store_overflow = 1'b0;
      end
      WT_HIT: begin
        ch = w[25:19];
        t = w[18:0];
        limit = (reg_channels > NUM_CHANNELS) ? NUM_CHANNELS : int'(reg_channels);
        depth = (reg_hits_kept > MAX_DEPTH) ? MAX_DEPTH : int'(reg_hits_kept);
        if (depth > ORDER_CAP) depth = ORDER_CAP;
        if (int'(ch) < limit) begin
          ord = chan_counts[ch];
          if (ch == reg_ref_channel && ord == 0) ref_time = t;
          if (int'(ord) < depth) begin
            if (stored_hits < HIT_STORE_SIZE) begin
              store_channel[stored_hits] = ch;
              store_order[stored_hits] = ord[3:0];
              store_time[stored_hits] = t;
              stored_hits++;
            end else begin
              store_overflow = 1'b1;
            end
          end
          if (ord != COUNT_MAX) chan_counts[ch] = ord + 5'd1;
        end
      end
      WT_ERROR: error_flags = w[14:0];
      WT_TRAILER: begin
        r.event_number = hdr_events;
        r.module_address = hdr_address;
        r.address_mismatch = (w[4:0] != hdr_address);
        r.trailer_status = w[26:24];
        r.last_error_flags = error_flags;
        r.hits_dropped = store_overflow;
        if (stored_hits == 0) begin
          r.has_hit = 1'b0;
          r.hit_channel = '0;
          r.hit_order = '0;
          r.relative_time = '0;
          r.last_of_event = 1'b1;
          hits_due.push_back(r);
        end else begin
          for (int i = 0; i < stored_hits; i++) begin
            r.has_hit = 1'b1;
            r.hit_channel = store_channel[i];
            r.hit_order = store_order[i];
            r.relative_time = {1'b0, store_time[i]} - {1'b0, ref_time};
            r.last_of_event = (i == stored_hits - 1);
            hits_due.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("result %0d at %0t: %s got %0h want %0h", results_seen, $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_hit(input hit_result_t r);
    if (hit_ch.has_hit !== r.has_hit)
      report_mismatch("has_hit", hit_ch.has_hit, r.has_hit);
    if (hit_ch.hit_channel !== r.hit_channel)
      report_mismatch("hit_channel", hit_ch.hit_channel, r.hit_channel);
    if (hit_ch.hit_order !== r.hit_order)
      report_mismatch("hit_order", hit_ch.hit_order, r.hit_order);
    if (hit_ch.relative_time !== r.relative_time)
      report_mismatch("relative_time", hit_ch.relative_time, r.relative_time);
    if (hit_ch.event_number !== r.event_number)
      report_mismatch("event_number", hit_ch.event_number, r.event_number);
    if (hit_ch.module_address !== r.module_address)
      report_mismatch("module_address", hit_ch.module_address, r.module_address);
    if (hit_ch.address_mismatch !== r.address_mismatch)
      report_mismatch("address_mismatch", hit_ch.address_mismatch, r.address_mismatch);
    if (hit_ch.trailer_status !== r.trailer_status)
      report_mismatch("trailer_status", hit_ch.trailer_status, r.trailer_status);
    if (hit_ch.last_error_flags !== r.last_error_flags)
      report_mismatch("last_error_flags", hit_ch.last_error_flags, r.last_error_flags);
    if (hit_ch.hits_dropped !== r.hits_dropped)
      report_mismatch("hits_dropped", hit_ch.hits_dropped, r.hits_dropped);
    if (hit_ch.last_of_event !== r.last_of_event)
      report_mismatch("last_of_event", hit_ch.last_of_event, r.last_of_event);
  endtask

  // word sender
  always @(posedge clk) begin
    logic next_valid;
    logic [31:0] next_word;
    if (rst) begin
      word_ch.valid <= 1'b0;
      word_ch.data_word <= '0;
    end else begin
      next_valid = word_ch.valid;
      next_word = word_ch.data_word;
      if (word_ch.valid && word_ch.ready) begin
        decode_word(word_ch.data_word);
        words_to_send.delete(0);
        next_valid = 1'b0;
      end
      if (!next_valid && words_to_send.size() != 0
          && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
        next_valid = 1'b1;
        next_word = words_to_send[0];
      end
      word_ch.valid <= next_valid;
      word_ch.data_word <= next_word;
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (rst) begin
      hit_ch.ready <= 1'b0;
    end else begin
      if (hit_ch.valid && hit_ch.ready) begin
        if (hits_due.size() == 0) report_mismatch("unexpected result", 0, 0);
        else check_hit(hits_due.pop_front());
        results_seen++;
      end
      if (hold_req && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        hit_ch.ready <= 1'b0;
      end else begin
        hit_ch.ready <= steady || $urandom_range(99) >= IDLE_PERCENT;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (word_ch.valid && word_ch.ready) || (hit_ch.valid && hit_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] hit_word(input logic [6:0] ch, input logic [18:0] t);
    return {WT_HIT, 1'($urandom), ch, t};
  endfunction

  function automatic logic [31:0] header_word(input logic [4:0] addr, input logic [21:0] evt);
    return {WT_HEADER, evt, addr};
  endfunction

  function automatic logic [31:0] trailer_word(input logic [4:0] addr, input logic [2:0] status);
    return {WT_TRAILER, status, 19'($urandom), addr};
  endfunction

  function automatic logic [31:0] error_word(input logic [14:0] flags);
    return {WT_ERROR, 12'($urandom), flags};
  endfunction

  function automatic logic [4:0] noise_type();
    logic [4:0] k;
    k = 5'($urandom_range(31));
    while (k == WT_HIT || k == WT_ERROR || k == WT_HEADER || k == WT_TRAILER)
      k = 5'($urandom_range(31));
    return k;
  endfunction

  // mostly a few busy channels so that depth and the counters matter
  function automatic logic [6:0] pick_channel();
    int lim;
    int r;
    lim = (reg_channels > NUM_CHANNELS) ? NUM_CHANNELS : int'(reg_channels);
    r = $urandom_range(99);
    if (r < 20) return reg_ref_channel;
    if (lim == 0 || r >= 85) return 7'($urandom_range(127));
    if (r < 55) return 7'($urandom_range((lim < 4) ? lim - 1 : 3));
    return 7'($urandom_range(lim - 1));
  endfunction

  task automatic add_event(input int n_hits);
    logic [4:0] addr;
    addr = 5'($urandom);
    if ($urandom_range(99) >= 8) words_to_send.push_back(header_word(addr, 22'($urandom)));
    if ($urandom_range(99) < 35) words_to_send.push_back(error_word(15'($urandom)));
    for (int i = 0; i < n_hits; i++) begin
      if ($urandom_range(99) < 6) words_to_send.push_back({noise_type(), 27'($urandom)});
      words_to_send.push_back(hit_word(pick_channel(), 19'($urandom)));
    end
    if ($urandom_range(99) >= 8) begin
      if ($urandom_range(99) >= 85) addr = 5'($urandom);
      words_to_send.push_back(trailer_word(addr, 3'($urandom)));
      if ($urandom_range(99) < 8) words_to_send.push_back(trailer_word(addr, 3'($urandom)));
    end
  endtask

  task automatic add_events(input int budget);
    int added;
    int size0;
    added = 0;
    while (added < budget) begin
      size0 = words_to_send.size();
      add_event(($urandom_range(99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 20));
      added += words_to_send.size() - size0;
    end
  endtask

  task automatic add_burst(input int n_hits, input int base, input int n_chans);
    logic [4:0] addr;
    addr = 5'($urandom);
    words_to_send.push_back(header_word(addr, 22'($urandom)));
    for (int i = 0; i < n_hits; i++)
      words_to_send.push_back(hit_word(7'(base + i % n_chans), 19'($urandom)));
    words_to_send.push_back(trailer_word(addr, 3'($urandom)));
  endtask

  task automatic settle();
    while (words_to_send.size() != 0 || hits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_REF_CHANNEL:   reg_ref_channel = val[6:0];
      CFG_CHANNELS_USED: reg_channels = val;
      CFG_HITS_KEPT:     reg_hits_kept = val[4:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] ref_ch, input logic [7:0] used,
                            input logic [7:0] kept);
    write_reg(CFG_REF_CHANNEL, ref_ch);
    write_reg(CFG_CHANNELS_USED, used);
    write_reg(CFG_HITS_KEPT, kept);
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    word_ch.valid = 1'b0;
    word_ch.data_word = '0;
    hit_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset configuration, directed words first
    words_to_send.push_back(header_word(5'h1F, 22'h3FFFFF));
    words_to_send.push_back(trailer_word(5'h1F, 3'h7));
    words_to_send.push_back(error_word(15'h7FFF));
    words_to_send.push_back(hit_word(7'd0, 19'h7FFFF));
    words_to_send.push_back(hit_word(7'd127, 19'h00000));
    words_to_send.push_back(hit_word(7'd127, 19'h00001));
    words_to_send.push_back(hit_word(7'd0, 19'h00005));
    words_to_send.push_back({WT_TDC_HEADER, 27'h7FFFFFF});
    words_to_send.push_back({WT_TDC_TRAILER, 27'h0000000});
    words_to_send.push_back({WT_FILLER, 27'h5A5A5A5});
    words_to_send.push_back(trailer_word(5'h00, 3'h0));
    words_to_send.push_back(trailer_word(5'h1F, 3'h5));
    words_to_send.push_back(header_word(5'h00, 22'h000000));
    for (int i = 0; i < 6; i++)
      words_to_send.push_back(hit_word(7'd3, 19'(i * 1000)));
    words_to_send.push_back(error_word(15'h0000));
    words_to_send.push_back(trailer_word(5'h00, 3'h2));
    add_events(14);
    settle();

    // full store while the receiver holds off
    set_config(8'd127, 8'd128, 8'd16);
    hold_req <= 1'b1;
    add_burst(66, 0, 5);
    add_events(8);
    settle();

    // single channel, single hit
    set_config(8'd0, 8'd1, 8'd1);
    add_events(10);
    settle();

    // zero depth keeps the reference time only
    set_config(8'd5, 8'd128, 8'd0);
    add_events(8);
    settle();

    write_reg(CFG_CHANNELS_USED, 8'd0);
    write_reg(CFG_HITS_KEPT, 8'd2);
    add_events(6);
    settle();

    // counter saturation on one channel
    set_config(8'($urandom_range(127)), 8'd200, 8'd31);
    add_burst(34, $urandom_range(127), 1);
    add_events(6);
    settle();

    // no idling on either side
    set_config(8'($urandom_range(127)), 8'($urandom_range(1, 128)), 8'($urandom_range(1, 16)));
    @(posedge clk);
    steady <= 1'b1;
    add_events(28);
    settle();
    steady <= 1'b0;

    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

### tdc_event_hit_decoder.f
hdl/tdc_ehd_pkg.sv
hdl/tdc_ehd_if.sv
hdl/tdc_ehd_ram.sv
hdl/tdc_ehd_front.sv
hdl/tdc_ehd_fifo.sv
hdl/tdc_ehd_back.sv
hdl/tdc_event_hit_decoder.sv
tb/tdc_event_hit_decoder_test.sv
